@@ hw/rtl/cau_pkg.sv @@
// shared types and constants of the complex arithmetic unit
// no dependencies; used by the interfaces and every module of the block
package cau_pkg;

	localparam int OPERAND_WIDTH_DEF = 16;
	localparam int RES_W             = 32;
	localparam int QUOT_BITS         = 32;
	localparam int SCALE_BITS        = 16;
	localparam int FRAC_BITS         = 8;
	localparam int QUEUE_DEPTH       = 4;

	typedef enum logic [1:0] {
		KIND_ADD = 2'd0,
		KIND_SUB = 2'd1,
		KIND_MUL = 2'd2,
		KIND_DIV = 2'd3
	} kind_t;

	// classification of one item, handed from the front end to the divider side
	typedef struct packed {
		logic is_div;
		logic dz;
		logic sat;
		logic neg_re;
		logic neg_im;
		logic big_re;
		logic big_im;
	} ctrl_t;

endpackage

@@ hw/rtl/cau_in_if.sv @@
// operand channel: valid/ready handshake with kind and two complex operands
// depends on cau_pkg
interface cau_in_if #(
	parameter int W = cau_pkg::OPERAND_WIDTH_DEF
);
	logic                valid;
	logic                ready;
	logic [1:0]          kind;
	logic signed [W-1:0] x_re;
	logic signed [W-1:0] x_im;
	logic signed [W-1:0] y_re;
	logic signed [W-1:0] y_im;

	modport source (output valid, kind, x_re, x_im, y_re, y_im, input ready);
	modport sink   (input valid, kind, x_re, x_im, y_re, y_im, output ready);
endinterface

@@ hw/rtl/cau_out_if.sv @@
// result channel: valid/ready handshake with complex Q16.16 result and flags
// depends on cau_pkg
interface cau_out_if;
	logic                                valid;
	logic                                ready;
	logic signed [cau_pkg::RES_W-1:0]    result_re;
	logic signed [cau_pkg::RES_W-1:0]    result_im;
	logic                                div_by_zero;
	logic                                saturated;

	modport source (output valid, result_re, result_im, div_by_zero, saturated,
		input ready);
	modport sink   (input valid, result_re, result_im, div_by_zero, saturated,
		output ready);
endinterface

@@ hw/rtl/cau_front.sv @@
// front end: accepts operand transactions, forms products, sums and the divisor
// magnitude, finishes add/sub/mul results and classifies divides; uses cau_pkg
module cau_front #(
	parameter int W = cau_pkg::OPERAND_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	cau_in_if.sink                       operands,
	output logic                         push_valid,
	input  logic                         push_ready,
	output cau_pkg::ctrl_t               push_ctrl,
	output logic [cau_pkg::RES_W-1:0]    push_pre_re,
	output logic [cau_pkg::RES_W-1:0]    push_pre_im,
	output logic [2*W:0]                 push_mag_re,
	output logic [2*W:0]                 push_mag_im,
	output logic [2*W-1:0]               push_den
);
	import cau_pkg::*;

	localparam int PW  = 2 * W;
	localparam int SW  = 2 * W + 1;
	localparam int CLW = (SW > RES_W + 1) ? SW : RES_W + 1;
	localparam int BW  = SW + SCALE_BITS;

	logic adv;
	logic v_s1, v_s2, v_s3;

	kind_t                kind_s1, kind_s2;
	logic signed [PW-1:0] prr_s1, pii_s1, pri_s1, pir_s1, yyr_s1, yyi_s1;
	logic signed [W:0]    sr_s1, si_s1;
	logic signed [SW-1:0] sum_re_s2, sum_im_s2;
	logic [PW-1:0]        den_s2;

	ctrl_t                ctrl_s3;
	logic [RES_W-1:0]     pre_re_s3, pre_im_s3;
	logic [SW-1:0]        mag_re_s3, mag_im_s3;
	logic [PW-1:0]        den_s3;

	// signed clip to the result range, returns {sat, value}
	function automatic logic [RES_W:0] clip_res(input logic signed [SW-1:0] v);
		logic signed [CLW-1:0] e;
		logic signed [CLW-1:0] hi;
		logic signed [CLW-1:0] lo;
		logic [RES_W:0]        r;
		e  = CLW'(v);
		hi = CLW'(32'sh7FFF_FFFF);
		lo = CLW'(32'sh8000_0000);
		if (e > hi) begin
			r = {1'b1, 32'h7FFF_FFFF};
		end else if (e < lo) begin
			r = {1'b1, 32'h8000_0000};
		end else begin
			r = {1'b0, e[RES_W-1:0]};
		end
		return r;
	endfunction

	function automatic logic [SW-1:0] mag_of(input logic signed [SW-1:0] v);
		logic signed [SW-1:0] n;
		n = -v;
		return v[SW-1] ? $unsigned(n) : $unsigned(v);
	endfunction

	assign adv            = !v_s3 || push_ready;
	assign operands.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= operands.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// stage 1: all products and the add/sub sums
	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s1 <= kind_t'(operands.kind);
			prr_s1  <= operands.x_re * operands.y_re;
			pii_s1  <= operands.x_im * operands.y_im;
			pri_s1  <= operands.x_re * operands.y_im;
			pir_s1  <= operands.x_im * operands.y_re;
			yyr_s1  <= operands.y_re * operands.y_re;
			yyi_s1  <= operands.y_im * operands.y_im;
			if (kind_t'(operands.kind) == KIND_SUB) begin
				sr_s1 <= (W+1)'(operands.x_re) - (W+1)'(operands.y_re);
				si_s1 <= (W+1)'(operands.x_im) - (W+1)'(operands.y_im);
			end else begin
				sr_s1 <= (W+1)'(operands.x_re) + (W+1)'(operands.y_re);
				si_s1 <= (W+1)'(operands.x_im) + (W+1)'(operands.y_im);
			end
		end
	end

	// stage 2: combine products per operation
	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s2 <= kind_s1;
			den_s2  <= $unsigned(yyr_s1) + $unsigned(yyi_s1);
			case (kind_s1)
				KIND_ADD, KIND_SUB: begin
					sum_re_s2 <= SW'(sr_s1) <<< FRAC_BITS;
					sum_im_s2 <= SW'(si_s1) <<< FRAC_BITS;
				end
				KIND_MUL: begin
					sum_re_s2 <= SW'(prr_s1) - SW'(pii_s1);
					sum_im_s2 <= SW'(pri_s1) + SW'(pir_s1);
				end
				default: begin
					sum_re_s2 <= SW'(prr_s1) + SW'(pii_s1);
					sum_im_s2 <= SW'(pir_s1) - SW'(pri_s1);
				end
			endcase
		end
	end

	// stage 3: finish non-divide results, classify divides
	always_ff @(posedge clk) begin
		logic [RES_W:0] cr;
		logic [RES_W:0] ci;
		logic [SW-1:0]  mr;
		logic [SW-1:0]  mi;
		logic [BW-1:0]  dsh;
		if (adv) begin
			cr  = clip_res(sum_re_s2);
			ci  = clip_res(sum_im_s2);
			mr  = mag_of(sum_re_s2);
			mi  = mag_of(sum_im_s2);
			dsh = BW'({den_s2, {SCALE_BITS{1'b0}}});
			pre_re_s3      <= cr[RES_W-1:0];
			pre_im_s3      <= ci[RES_W-1:0];
			mag_re_s3      <= mr;
			mag_im_s3      <= mi;
			den_s3         <= den_s2;
			ctrl_s3.is_div <= (kind_s2 == KIND_DIV);
			ctrl_s3.dz     <= (kind_s2 == KIND_DIV) && (den_s2 == '0);
			ctrl_s3.sat    <= cr[RES_W] | ci[RES_W];
			ctrl_s3.neg_re <= sum_re_s2[SW-1];
			ctrl_s3.neg_im <= sum_im_s2[SW-1];
			ctrl_s3.big_re <= BW'(mr) >= dsh;
			ctrl_s3.big_im <= BW'(mi) >= dsh;
		end
	end

	assign push_valid  = v_s3;
	assign push_ctrl   = ctrl_s3;
	assign push_pre_re = pre_re_s3;
	assign push_pre_im = pre_im_s3;
	assign push_mag_re = mag_re_s3;
	assign push_mag_im = mag_im_s3;
	assign push_den    = den_s3;

endmodule

@@ hw/rtl/cau_queue.sv @@
// small fifo that decouples the front end from the divider pipeline
// uses cau_pkg for the default depth
module cau_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = cau_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             empty
);
	import cau_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_q, rd_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push, do_pop;

	assign full     = (cnt_q == CW'(DEPTH));
	assign empty    = (cnt_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_data;
		end
	end

endmodule

@@ hw/rtl/cau_back.sv @@
// back end: 32-stage restoring divider for both quotient parts sharing one
// divisor, final clip and the result register; uses cau_pkg
module cau_back #(
	parameter int W = cau_pkg::OPERAND_WIDTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      head_valid,
	output logic                      pop,
	input  cau_pkg::ctrl_t            head_ctrl,
	input  logic [cau_pkg::RES_W-1:0] head_pre_re,
	input  logic [cau_pkg::RES_W-1:0] head_pre_im,
	input  logic [2*W:0]              head_mag_re,
	input  logic [2*W:0]              head_mag_im,
	input  logic [2*W-1:0]            head_den,
	cau_out_if.source                 result
);
	import cau_pkg::*;

	localparam int PW = 2 * W;
	localparam int SW = 2 * W + 1;
	localparam int NW = SW + SCALE_BITS;
	localparam int CW = PW + QUOT_BITS;
	localparam int NS = QUOT_BITS;

	logic adv;

	logic                 v_q      [NS+1];
	ctrl_t                ctrl_q   [NS+1];
	logic [RES_W-1:0]     pre_re_q [NS+1];
	logic [RES_W-1:0]     pre_im_q [NS+1];
	logic [NW-1:0]        rre_q    [NS+1];
	logic [NW-1:0]        rim_q    [NS+1];
	logic [PW-1:0]        den_q    [NS+1];
	logic [QUOT_BITS-1:0] qre_q    [NS+1];
	logic [QUOT_BITS-1:0] qim_q    [NS+1];

	logic [NW-1:0]        rre_nx   [NS];
	logic [NW-1:0]        rim_nx   [NS];
	logic [QUOT_BITS-1:0] qre_nx   [NS];
	logic [QUOT_BITS-1:0] qim_nx   [NS];

	logic                 out_v_q;
	logic [RES_W-1:0]     out_re_q, out_im_q;
	logic                 out_dz_q, out_sat_q;

	// quotient to signed result with saturation, returns {sat, value}
	function automatic logic [RES_W:0] fix_quot(input logic neg, input logic big,
		input logic [QUOT_BITS-1:0] q);
		logic           s;
		logic [RES_W:0] r;
		if (!neg) begin
			s = big || q[QUOT_BITS-1];
			r = {s, s ? 32'h7FFF_FFFF : q};
		end else begin
			s = big || (q > 32'h8000_0000);
			r = {s, s ? 32'h8000_0000 : (~q + 1'b1)};
		end
		return r;
	endfunction

	assign adv = !out_v_q || result.ready;
	assign pop = adv && head_valid;

	// one quotient bit per stage, most significant first
	always_comb begin
		logic [CW-1:0] dsh;
		logic [CW-1:0] ra;
		logic [CW-1:0] rb;
		for (int j = 0; j < NS; j++) begin
			dsh = CW'(den_q[j]) << (NS - 1 - j);
			ra  = CW'(rre_q[j]);
			rb  = CW'(rim_q[j]);
			rre_nx[j] = rre_q[j];
			rim_nx[j] = rim_q[j];
			qre_nx[j] = qre_q[j];
			qim_nx[j] = qim_q[j];
			if (ra >= dsh) begin
				rre_nx[j]            = NW'(ra - dsh);
				qre_nx[j][NS - 1 - j] = 1'b1;
			end
			if (rb >= dsh) begin
				rim_nx[j]            = NW'(rb - dsh);
				qim_nx[j][NS - 1 - j] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j <= NS; j++) begin
				v_q[j] <= 1'b0;
			end
			out_v_q <= 1'b0;
		end else if (adv) begin
			v_q[0] <= head_valid;
			for (int j = 0; j < NS; j++) begin
				v_q[j+1] <= v_q[j];
			end
			out_v_q <= v_q[NS];
		end
	end

	always_ff @(posedge clk) begin
		logic [RES_W:0] fr;
		logic [RES_W:0] fi;
		if (adv) begin
			ctrl_q[0]   <= head_ctrl;
			pre_re_q[0] <= head_pre_re;
			pre_im_q[0] <= head_pre_im;
			rre_q[0]    <= {head_mag_re, {SCALE_BITS{1'b0}}};
			rim_q[0]    <= {head_mag_im, {SCALE_BITS{1'b0}}};
			den_q[0]    <= head_den;
			qre_q[0]    <= '0;
			qim_q[0]    <= '0;
			for (int j = 0; j < NS; j++) begin
				ctrl_q[j+1]   <= ctrl_q[j];
				pre_re_q[j+1] <= pre_re_q[j];
				pre_im_q[j+1] <= pre_im_q[j];
				den_q[j+1]    <= den_q[j];
				rre_q[j+1]    <= rre_nx[j];
				rim_q[j+1]    <= rim_nx[j];
				qre_q[j+1]    <= qre_nx[j];
				qim_q[j+1]    <= qim_nx[j];
			end

			fr = fix_quot(ctrl_q[NS].neg_re, ctrl_q[NS].big_re, qre_q[NS]);
			fi = fix_quot(ctrl_q[NS].neg_im, ctrl_q[NS].big_im, qim_q[NS]);
			if (!ctrl_q[NS].is_div) begin
				out_re_q  <= pre_re_q[NS];
				out_im_q  <= pre_im_q[NS];
				out_dz_q  <= 1'b0;
				out_sat_q <= ctrl_q[NS].sat;
			end else if (ctrl_q[NS].dz) begin
				out_re_q  <= '0;
				out_im_q  <= '0;
				out_dz_q  <= 1'b1;
				out_sat_q <= 1'b0;
			end else begin
				out_re_q  <= fr[RES_W-1:0];
				out_im_q  <= fi[RES_W-1:0];
				out_dz_q  <= 1'b0;
				out_sat_q <= fr[RES_W] | fi[RES_W];
			end
		end
	end

	assign result.valid       = out_v_q;
	assign result.result_re   = out_re_q;
	assign result.result_im   = out_im_q;
	assign result.div_by_zero = out_dz_q;
	assign result.saturated   = out_sat_q;

endmodule

@@ hw/rtl/complex_arith_unit.sv @@
// top level of the complex arithmetic unit: front end, queue, divider back end
// depends on cau_pkg, cau_in_if, cau_out_if, cau_front, cau_queue, cau_back
//
//  channel    | dir | handshake          | payload
//  operands   | in  | valid/ready        | kind, x_re, x_im, y_re, y_im (Q8.8)
//  result     | out | valid/ready        | result_re, result_im (Q16.16), flags
//
// one transaction per cycle sustained while the result side accepts, every operation;
// results pass three front stages, the queue and the 32-stage divider
// that every item passes through to keep results in order.
// reset clears only the valid bits and the queue pointers and count.
// a stalled result freezes the back end; the queue then absorbs the front end
// until it fills, at which point operands.ready drops.
module complex_arith_unit #(
	parameter int OPERAND_WIDTH = cau_pkg::OPERAND_WIDTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	cau_in_if.sink    operands,
	cau_out_if.source result
);
	import cau_pkg::*;

	localparam int SW = 2 * OPERAND_WIDTH + 1;
	localparam int PW = 2 * OPERAND_WIDTH;
	localparam int QW = $bits(ctrl_t) + 2 * RES_W + 2 * SW + PW;

	logic             push_valid, q_full, q_empty, pop;
	ctrl_t            push_ctrl, head_ctrl;
	logic [RES_W-1:0] push_pre_re, push_pre_im, head_pre_re, head_pre_im;
	logic [SW-1:0]    push_mag_re, push_mag_im, head_mag_re, head_mag_im;
	logic [PW-1:0]    push_den, head_den;
	logic [QW-1:0]    q_in, q_out;

	cau_front #(.W(OPERAND_WIDTH)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.operands    (operands),
		.push_valid  (push_valid),
		.push_ready  (!q_full),
		.push_ctrl   (push_ctrl),
		.push_pre_re (push_pre_re),
		.push_pre_im (push_pre_im),
		.push_mag_re (push_mag_re),
		.push_mag_im (push_mag_im),
		.push_den    (push_den)
	);

	assign q_in = {push_ctrl, push_pre_re, push_pre_im, push_mag_re, push_mag_im, push_den};
	assign {head_ctrl, head_pre_re, head_pre_im, head_mag_re, head_mag_im, head_den} = q_out;

	cau_queue #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push_valid),
		.push_data (q_in),
		.full      (q_full),
		.pop       (pop),
		.pop_data  (q_out),
		.empty     (q_empty)
	);

	cau_back #(.W(OPERAND_WIDTH)) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (!q_empty),
		.pop         (pop),
		.head_ctrl   (head_ctrl),
		.head_pre_re (head_pre_re),
		.head_pre_im (head_pre_im),
		.head_mag_re (head_mag_re),
		.head_mag_im (head_mag_im),
		.head_den    (head_den),
		.result      (result)
	);

endmodule

@@ tb/complex_arith_unit_test.sv @@
// testbench for complex_arith_unit: directed and random operand streams, results checked
// against a behavioral complex ALU model; depends on cau_pkg, cau_in_if, cau_out_if
`timescale 1ns / 100ps

module complex_arith_unit_test;
	import cau_pkg::*;

	localparam int OP_W = OPERAND_WIDTH_DEF;
	localparam int STALL_LIMIT = 20000;

	typedef struct packed {
		logic [31:0] re;
		logic [31:0] im;
		logic        dz;
		logic        sat;
	} alu_result_t;

	logic clk;
	logic arst_n;

	cau_in_if #(.W(OP_W)) operands ();
	cau_out_if result ();

	complex_arith_unit #(.OPERAND_WIDTH(OP_W)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.operands(operands.sink),
		.result(result.source)
	);

	alu_result_t pending_results[$];
	int mismatches;
	int checked;
	int idle_cycles;
	int sent;
	bit hold_off;
	bit random_idle;
	int div_count, dz_count, sat_count;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// clip a signed 64-bit value to 32 bits
	function automatic logic [31:0] clip_part(input longint v, inout logic sat);
		if (v > 64'sd2147483647) begin
			sat = 1'b1;
			return 32'h7FFFFFFF;
		end
		if (v < -64'sd2147483648) begin
			sat = 1'b1;
			return 32'h80000000;
		end
		return v[31:0];
	endfunction

	// numerator scaled by 2^16 over den, truncated toward zero
	function automatic logic [31:0] quotient_part(input longint num, input longint den,
			inout logic sat);
		longint unsigned mag;
		longint unsigned q;
		mag = (num < 0) ? -num : num;
		if (mag / den >= 64'd65536) begin
			q = 64'hFF_FFFF_FFFF;
		end else begin
			q = (mag << 16) / den;
		end
		if (num < 0)
			return clip_part(-longint'(q), sat);
		return clip_part(longint'(q), sat);
	endfunction

	function automatic alu_result_t complex_alu(input kind_t k, input logic [OP_W-1:0] a_re,
			input logic [OP_W-1:0] a_im, input logic [OP_W-1:0] b_re,
			input logic [OP_W-1:0] b_im);
		alu_result_t r;
		longint xr, xi, yr, yi, den;
		logic sat;
		xr = longint'($signed(a_re));
		xi = longint'($signed(a_im));
		yr = longint'($signed(b_re));
		yi = longint'($signed(b_im));
		sat = 1'b0;
		r = '0;
		case (k)
			KIND_ADD: begin
				r.re = clip_part((xr + yr) * 256, sat);
				r.im = clip_part((xi + yi) * 256, sat);
			end
			KIND_SUB: begin
				r.re = clip_part((xr - yr) * 256, sat);
				r.im = clip_part((xi - yi) * 256, sat);
			end
			KIND_MUL: begin
				r.re = clip_part(xr * yr - xi * yi, sat);
				r.im = clip_part(xr * yi + xi * yr, sat);
			end
			default: begin
				den = yr * yr + yi * yi;
				if (den == 0) begin
					r.dz = 1'b1;
				end else begin
					r.re = quotient_part(xr * yr + xi * yi, den, sat);
					r.im = quotient_part(xi * yr - xr * yi, den, sat);
				end
			end
		endcase
		r.sat = sat;
		return r;
	endfunction

	task automatic send_operands(input kind_t k, input logic [OP_W-1:0] a_re,
			input logic [OP_W-1:0] a_im, input logic [OP_W-1:0] b_re,
			input logic [OP_W-1:0] b_im);
		int gap;
		gap = random_idle ? $urandom_range(0, 15) : 0;
		if (gap != 0) begin
			operands.valid <= 1'b0;
			repeat (gap)
				@(posedge clk);
		end
		operands.valid <= 1'b1;
		operands.kind <= k;
		operands.x_re <= a_re;
		operands.x_im <= a_im;
		operands.y_re <= b_re;
		operands.y_im <= b_im;
		@(posedge clk);
		while (!operands.ready)
			@(posedge clk);
		pending_results.push_back(complex_alu(k, a_re, a_im, b_re, b_im));
		sent++;
		if (k == KIND_DIV)
			div_count++;
		// valid stays high; the next call lowers it only if it draws a gap
	endtask

	task automatic finish_stream;
		operands.valid <= 1'b0;
	endtask

	// result checker
	always @(posedge clk) begin
		alu_result_t exp_r;
		if (arst_n && result.valid && result.ready) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result transaction re=%h im=%h",
						result.result_re, result.result_im);
			end else begin
				exp_r = pending_results.pop_front();
				checked++;
				if (exp_r.dz)
					dz_count++;
				if (exp_r.sat)
					sat_count++;
				if (exp_r.re !== result.result_re || exp_r.im !== result.result_im ||
						exp_r.dz !== result.div_by_zero ||
						exp_r.sat !== result.saturated) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected re=%h im=%h dz=%b sat=%b, got re=%h im=%h dz=%b sat=%b",
							exp_r.re, exp_r.im, exp_r.dz, exp_r.sat,
							result.result_re, result.result_im,
							result.div_by_zero, result.saturated);
				end
			end
		end
	end

	// receiver stalls
	initial begin
		int stall;
		result.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off) begin
				result.ready <= 1'b0;
			end else if (random_idle) begin
				stall = $urandom_range(0, 15);
				if (stall != 0 && $urandom_range(0, 3) == 0) begin
					result.ready <= 1'b0;
					repeat (stall - 1)
						@(posedge clk);
				end
				result.ready <= 1'b1;
			end else begin
				result.ready <= 1'b1;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((operands.valid && operands.ready) || (result.valid && result.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("timeout: no transaction for %0d cycles", STALL_LIMIT);
			$display("complex_arith_unit verification failed");
			$finish;
		end
	end

	function automatic logic [OP_W-1:0] pick_operand;
		case ($urandom_range(0, 7))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return '0;
			3: return 16'(int'($urandom_range(0, 1023)) - 512);
			default: return OP_W'($urandom());
		endcase
	endfunction

	task automatic test_directed;
		logic [OP_W-1:0] ext[4];
		ext = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF};
		for (int k = 0; k < 4; k++) begin
			send_operands(kind_t'(k), ext[0], ext[1], ext[1], ext[0]);
			send_operands(kind_t'(k), ext[1], ext[0], ext[3], ext[3]);
		end
		// multiply overflow on the imaginary part
		send_operands(KIND_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
		// divide by zero
		send_operands(KIND_DIV, 16'h1234, 16'hFEDC, 16'h0000, 16'h0000);
		send_operands(KIND_DIV, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
		// quotient saturation: large over tiny divisor, both signs
		send_operands(KIND_DIV, 16'h7FFF, 16'h8000, 16'h0001, 16'h0000);
		send_operands(KIND_DIV, 16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF);
		send_operands(KIND_DIV, 16'h0100, 16'h0000, 16'h0100, 16'h0000);
		send_operands(KIND_DIV, 16'hFF00, 16'h0080, 16'h0003, 16'hFFFD);
		send_operands(KIND_ADD, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
	endtask

	task automatic test_random(input int count);
		for (int i = 0; i < count; i++)
			send_operands(kind_t'($urandom_range(0, 3)), pick_operand(), pick_operand(),
				pick_operand(), pick_operand());
	endtask

	task automatic test_backpressure;
		fork
			begin
				hold_off = 1'b1;
				repeat (1000)
					@(posedge clk);
				hold_off = 1'b0;
			end
			test_random(100);
		join
	endtask

	task automatic wait_drain;
		int guard;
		guard = 0;
		while (pending_results.size() != 0 && guard < 100000) begin
			@(posedge clk);
			guard++;
		end
		repeat (60)
			@(posedge clk);
	endtask

	initial begin
		mismatches = 0;
		checked = 0;
		sent = 0;
		idle_cycles = 0;
		hold_off = 1'b0;
		random_idle = 1'b0;
		div_count = 0;
		dz_count = 0;
		sat_count = 0;
		arst_n = 1'b0;
		operands.valid = 1'b0;
		operands.kind = KIND_ADD;
		operands.x_re = '0;
		operands.x_im = '0;
		operands.y_re = '0;
		operands.y_im = '0;
		repeat (4)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(200);
		random_idle = 1'b1;
		test_random(900);
		test_backpressure();
		random_idle = 1'b0;
		test_random(100);
		finish_stream();
		wait_drain();
		$display("sent %0d operand transactions, checked %0d results", sent, checked);
		$display("divides %0d, zero divisors %0d, saturations %0d", div_count, dz_count,
			sat_count);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("complex_arith_unit verification clean");
		end else begin
			$display("%0d mismatches, %0d results missing", mismatches,
				pending_results.size());
			$display("complex_arith_unit verification failed");
		end
		$finish;
	end

endmodule

@@ files.f @@
hw/rtl/cau_pkg.sv
hw/rtl/cau_in_if.sv
hw/rtl/cau_out_if.sv
hw/rtl/cau_front.sv
hw/rtl/cau_queue.sv
hw/rtl/cau_back.sv
hw/rtl/complex_arith_unit.sv
tb/complex_arith_unit_test.sv
